// ----- rtl/bitplane_run_length_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// bitplane run-length encoder assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BITPLANE_RUN_LENGTH_ENCODER_MACROS_SVH
`define BITPLANE_RUN_LENGTH_ENCODER_MACROS_SVH

// same-cycle implication
`define BRLE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/brle_pkg.sv -----
// ----------------------------------------------------------------------------
// brle_pkg
// types and constants shared by the bitplane run-length encoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brle_pkg;

	localparam int unsigned PIXEL_W = 8;
	localparam int unsigned PLANE_W = 3;
	localparam int unsigned CODE_W  = 8;

	// longest run one byte can carry
	localparam logic [CODE_W-1:0] FULL_RUN = 8'd255;
	localparam logic [PLANE_W-1:0] PLANE_RESET = 3'd7;

	// one queued request from front to back: one or two code bytes of one pixel
	typedef struct packed {
		logic              two;   // b1 follows b0
		logic [CODE_W-1:0] b0;
		logic [CODE_W-1:0] b1;
		logic              done;  // final byte of the entry closes the row
	} entry_t;

	// queue status seen by the top level and the back
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

// ----- rtl/bitplane_run_length_encoder.sv -----
// ----------------------------------------------------------------------------
// bitplane_run_length_encoder
// codes one bit-plane of a pixel stream as alternating run-length bytes
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall): one pixel per request, row_end on the
//   last pixel of a row. in_stall rises only when the entry queue is full.
//   output channel (out_valid / out_stall): one code byte per request, with
//   item_last on the final byte of a pixel and row_done on the row's last byte.
//   config channel (cfg_valid / cfg_ready): cfg_data selects the bit-plane;
//   cfg_ready is always high, write only while the block is idle.
// path: a pixel's bytes go into the entry queue, then into the output register.
// throughput: one pixel per cycle in while in_stall is low, one byte per cycle
//   out while out_stall is low; a pixel that yields two bytes holds the back
//   end for both of them, the queue of QUEUE_DEPTH entries takes up the slack.
// reset: plane 7, empty queue, empty output register, encoder at row start.
// receiver stall: the output register holds; the queue keeps filling until
//   full, then in_stall is raised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitplane_run_length_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [brle_pkg::PLANE_W-1:0]        cfg_data,
	// pixel input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [brle_pkg::PIXEL_W-1:0]        pixel_value,
	input  logic                                row_end,
	// code byte output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [brle_pkg::CODE_W-1:0]         code_byte,
	output logic                                item_last,
	output logic                                row_done
);

	brle_pkg::entry_t    fe_entry;
	brle_pkg::entry_t    q_head;
	brle_pkg::q_status_t q_status;
	logic                fe_push;
	logic                be_pop;
	logic                in_accept;

	// registers accept writes at any time
	assign cfg_ready = 1'b1;

	// only a full queue holds the source off
	assign in_stall  = q_status.full;
	assign in_accept = in_valid && !q_status.full;

	// front: plane bit, run state, per-pixel bytes
	brle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.accept      (in_accept),
		.pixel_value (pixel_value),
		.row_end     (row_end),
		.push        (fe_push),
		.entry       (fe_entry)
	);

	// decoupling queue
	brle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_push),
		.wr_entry (fe_entry),
		.pop      (be_pop),
		.head     (q_head),
		.status   (q_status)
	);

	// back: byte serializer and output register
	brle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_status.not_empty),
		.pop        (be_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_byte  (code_byte),
		.item_last  (item_last),
		.row_done   (row_done)
	);

endmodule

// ----- rtl/brle_front.sv -----
// ----------------------------------------------------------------------------
// brle_front
// plane bit test, run tracking and packing of the code bytes of one pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brle_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [brle_pkg::PLANE_W-1:0]        cfg_data,
	input  logic                                accept,
	input  logic [brle_pkg::PIXEL_W-1:0]        pixel_value,
	input  logic                                row_end,
	output logic                                push,
	output brle_pkg::entry_t                    entry
);

	logic [brle_pkg::PLANE_W-1:0] plane_q;
	logic [brle_pkg::CODE_W-1:0]  len_q;
	logic                         pol_q;
	logic                         row_start_q;
	logic                         pending_q;

	logic                         bit_v;
	logic                         first_en;
	logic [brle_pkg::CODE_W-1:0]  first_byte;
	logic [brle_pkg::CODE_W-1:0]  len1;
	logic                         full_close;

	always_comb begin
		bit_v      = pixel_value[plane_q];
		first_en   = 1'b0;
		first_byte = '0;
		len1       = brle_pkg::CODE_W'(1);
		if (row_start_q) begin
			first_en = bit_v;           // row opening on a one: empty zero run
		end else if (pending_q) begin
			first_en = (bit_v == pol_q); // run goes on past 255: empty opposite run
		end else if (bit_v == pol_q) begin
			len1 = (len_q < brle_pkg::FULL_RUN) ? len_q + 1'b1 : len_q;
		end else begin
			first_en   = 1'b1;
			first_byte = len_q;
		end
		full_close = !row_end && (len1 == brle_pkg::FULL_RUN);
	end

	// pack the bytes of this pixel into one queue entry
	always_comb begin
		entry.two  = first_en && (row_end || full_close);
		entry.b0   = first_en ? first_byte : len1;
		entry.b1   = len1;
		entry.done = row_end;
		push       = accept && (first_en || row_end || full_close);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= brle_pkg::PLANE_RESET;
		end else if (cfg_we) begin
			plane_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pol_q       <= 1'b0;
			row_start_q <= 1'b1;
			pending_q   <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				len_q       <= '0;
				pol_q       <= 1'b0;
				row_start_q <= 1'b1;
				pending_q   <= 1'b0;
			end else begin
				len_q       <= full_close ? '0 : len1;
				pol_q       <= bit_v;
				row_start_q <= 1'b0;
				pending_q   <= full_close;
			end
		end
	end

endmodule

// ----- rtl/brle_queue.sv -----
// ----------------------------------------------------------------------------
// brle_queue
// short first-in first-out queue of code entries between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brle_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  brle_pkg::entry_t    wr_entry,
	input  logic                pop,
	output brle_pkg::entry_t    head,
	output brle_pkg::q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	brle_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head             = mem_q[rd_ptr_q];
	assign status.full      = (count_q == CNT_W'(DEPTH));
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/brle_back.sv -----
// ----------------------------------------------------------------------------
// brle_back
// splits queue entries into single code bytes and holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brle_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brle_pkg::entry_t             head,
	input  logic                         head_valid,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [brle_pkg::CODE_W-1:0]  code_byte,
	output logic                         item_last,
	output logic                         row_done
);

	logic                        valid_q;
	logic                        half_q;   // first byte of a two-byte entry already sent
	logic [brle_pkg::CODE_W-1:0] byte_q;
	logic                        last_q;
	logic                        done_q;

	logic                        load;
	logic                        final_byte;

	assign load       = !valid_q || !out_stall;
	assign final_byte = !head.two || half_q;
	assign pop        = load && head_valid && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				half_q <= !final_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			byte_q <= half_q ? head.b1 : head.b0;
			last_q <= final_byte;
			done_q <= final_byte && head.done;
		end
	end

	assign out_valid = valid_q;
	assign code_byte = byte_q;
	assign item_last = last_q;
	assign row_done  = done_q;

endmodule

// ----- rtl/brle_checker.sv -----
// ----------------------------------------------------------------------------
// brle_checker
// port-level checks on the encoder output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitplane_run_length_encoder_macros.svh"

module brle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] code_byte,
	input logic       item_last,
	input logic       row_done
);

	// held request keeps its byte
	`BRLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(code_byte), "stalled output byte changed")

	// a row always ends on the last byte of its pixel
	`BRLE_ASSERT_IMPL(a_row_done_last, out_valid && row_done, item_last, "row_done without item_last")

	// the closing run of a row holds at least one pixel
	`BRLE_ASSERT_IMPL(a_row_done_nonzero, out_valid && row_done, code_byte != 8'd0, "empty closing run")

	// the second byte of a pixel follows right after the first
	`BRLE_ASSERT_NEXT(a_pair_back_to_back, out_valid && !out_stall && !item_last, out_valid, "second byte of a pixel delayed")

endmodule

bind bitplane_run_length_encoder brle_checker u_brle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.code_byte (code_byte),
	.item_last (item_last),
	.row_done  (row_done)
);
